// File: sv/fwct_pkg.sv
// Package for the class-tally FIFO: action and status codes, widths, defaults.
// No dependencies.
`default_nettype none
package fwct_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF = 32;
	localparam int TOTAL_W = 20;
	localparam int DUR_W = 16;
	localparam int KIND_W = 8;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0,
		ACT_POP = 3'd1,
		ACT_CLEAR = 3'd2,
		ACT_PEEK_FRONT = 3'd3,
		ACT_PEEK_BACK = 3'd4,
		ACT_TALLY = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic do_push;
		logic do_pop;
		logic do_clear;
		logic rd_back;
		logic tally_start;
		logic scan_rd;    // read entry at scan index
		logic scan_acc;   // load registered read into result register (pop/peek)
		logic pass_two;
		logic wb_rd;      // read scratch for write back
		logic wb_wr;
		logic load_in;
		logic res_err_empty;
		logic res_err_full;
		logic res_zero;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
	} stat_t;
endpackage
`default_nettype wire

// File: sv/fwct_if.sv
// Valid/ready channel interfaces for input and result transactions.
// Depends on fwct_pkg.
`default_nettype none
interface fwct_in_if import fwct_pkg::*; #(parameter int TAG_BITS = TAG_BITS_DEF);
	logic valid;
	logic ready;
	logic [2:0] action;
	logic [31:0] name_tag;
	logic [31:0] prize_tag;
	logic [7:0] kind;
	logic [15:0] duration;
	modport source (output valid, action, name_tag, prize_tag, kind, duration, input ready);
	modport sink (input valid, action, name_tag, prize_tag, kind, duration, output ready);
endinterface

interface fwct_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [31:0] out_name;
	logic [31:0] out_prize;
	logic [7:0] out_kind;
	logic [15:0] out_duration;
	logic [19:0] total;
	modport source (output valid, status, out_name, out_prize, out_kind, out_duration, total,
		input ready);
	modport sink (input valid, status, out_name, out_prize, out_kind, out_duration, total,
		output ready);
endinterface
`default_nettype wire

// File: sv/fwct_datapath.sv
// Datapath: ring store, scratch store, pointers, tally accumulator, result register.
// Depends on fwct_pkg.
`default_nettype none
module fwct_datapath import fwct_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output stat_t stat,
	output logic scan_last,
	output logic wb_last,
	input wire logic [31:0] in_name,
	input wire logic [31:0] in_prize,
	input wire logic [7:0] in_kind,
	input wire logic [15:0] in_dur,
	output logic [1:0] r_status,
	output logic [31:0] r_name,
	output logic [31:0] r_prize,
	output logic [7:0] r_kind,
	output logic [15:0] r_dur,
	output logic [19:0] r_total
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 2 * TAG_BITS + KIND_W + DUR_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [EW-1:0] ring_q [QUEUE_DEPTH];
	logic [EW-1:0] scr_q [QUEUE_DEPTH];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // issue index for scan / write back
	logic [CW-1:0] n_q;        // scratch fill count
	logic [CW-1:0] wbi_q;      // write-back offset of registered data
	logic [EW-1:0] rd_q;
	logic [EW-1:0] srd_q;
	logic rd_v_q;
	logic wb_v_q;
	logic [KIND_W-1:0] want_q;
	logic [TOTAL_W-1:0] acc_q;

	function automatic logic [AW-1:0] rpos(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH))
			s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	logic [EW-1:0] push_e;
	assign push_e = {TAG_BITS'(in_name), TAG_BITS'(in_prize), in_kind, in_dur};

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q >= DEPTH_C);
	assign scan_last = (idx_q + 1'b1 >= count_q);
	assign wb_last = (idx_q + 1'b1 >= count_q);

	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = head_q;
		if (cmd.rd_back)
			rd_addr = rpos(head_q, count_q - 1'b1);
		else if (cmd.scan_rd)
			rd_addr = rpos(head_q, idx_q);
	end

	logic [KIND_W-1:0] rd_kind;
	logic [DUR_W-1:0] rd_dur;
	logic hit;
	logic [TOTAL_W:0] sum;
	assign rd_kind = rd_q[DUR_W +: KIND_W];
	assign rd_dur = rd_q[DUR_W-1:0];
	assign hit = (rd_kind == want_q) ^ cmd.pass_two;
	assign sum = {1'b0, acc_q} + (TOTAL_W+1)'(rd_dur);

	always_ff @(posedge clk) begin
		if (cmd.do_push && !stat.full)
			ring_q[rpos(head_q, count_q)] <= push_e;
		else if (wb_v_q)
			ring_q[rpos(head_q, wbi_q)] <= srd_q;
		rd_q <= ring_q[rd_addr];
		if (rd_v_q && hit)
			scr_q[n_q[AW-1:0]] <= rd_q;
		srd_q <= scr_q[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			rd_v_q <= 1'b0;
			wb_v_q <= 1'b0;
			wbi_q <= '0;
			acc_q <= '0;
		end else begin
			rd_v_q <= cmd.scan_rd;
			wb_v_q <= cmd.wb_rd;
			wbi_q <= idx_q;
			if (cmd.do_push && !stat.full)
				count_q <= count_q + 1'b1;
			if (cmd.do_pop && !stat.empty) begin
				head_q <= rpos(head_q, CW'(1));
				count_q <= count_q - 1'b1;
			end
			if (cmd.do_clear) begin
				head_q <= '0;
				count_q <= '0;
			end
			if (cmd.tally_start) begin
				idx_q <= '0;
				n_q <= '0;
				acc_q <= '0;
			end else if (cmd.scan_rd || cmd.wb_rd) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
			if (rd_v_q && hit) begin
				n_q <= n_q + 1'b1;
				if (!cmd.pass_two)
					acc_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			want_q <= in_kind;
	end

	// result register; peek/pop data comes from rd_q in the cycle after the read
	always_ff @(posedge clk) begin
		if (cmd.res_zero || cmd.res_err_empty || cmd.res_err_full) begin
			r_status <= cmd.res_err_empty ? ST_EMPTY : (cmd.res_err_full ? ST_FULL : ST_OK);
			r_name <= '0;
			r_prize <= '0;
			r_kind <= '0;
			r_dur <= '0;
			r_total <= '0;
		end else if (cmd.scan_acc) begin
			r_status <= ST_OK;
			r_name <= 32'(rd_q[EW-1 -: TAG_BITS]);
			r_prize <= 32'(rd_q[EW-1-TAG_BITS -: TAG_BITS]);
			r_kind <= rd_kind;
			r_dur <= rd_dur;
			r_total <= '0;
		end else if (cmd.wb_wr) begin
			r_status <= ST_OK;
			r_name <= '0;
			r_prize <= '0;
			r_kind <= '0;
			r_dur <= '0;
			r_total <= acc_q;
		end
	end
endmodule
`default_nettype wire

// File: sv/fwct_ctrl.sv
// Controller FSM: sequences actions, tally scan passes and write back, handshakes.
// Depends on fwct_pkg.
`default_nettype none
module fwct_ctrl import fwct_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] in_action,
	output logic out_valid,
	input wire logic out_ready,
	input wire stat_t stat,
	input wire logic scan_last,
	input wire logic wb_last,
	output cmd_t cmd
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_READ = 8'b00000010,
		S_P1 = 8'b00000100,
		S_P1D = 8'b00001000,
		S_P2 = 8'b00010000,
		S_P2D = 8'b00100000,
		S_WB = 8'b01000000,
		S_OUT = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic out_v_q;
	logic fire;
	logic start;

	assign in_ready = (state_q == S_IDLE) && !out_v_q;
	assign fire = in_valid && in_ready;
	assign out_valid = out_v_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					cmd.load_in = 1'b1;
					case (in_action)
						ACT_PUSH: begin
							cmd.do_push = 1'b1;
							cmd.res_err_full = stat.full;
							cmd.res_zero = !stat.full;
							start = 1'b1;
						end
						ACT_POP, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
							if (stat.empty) begin
								cmd.res_err_empty = 1'b1;
								start = 1'b1;
							end else begin
								cmd.rd_back = (in_action == ACT_PEEK_BACK);
								cmd.do_pop = (in_action == ACT_POP);
								state_d = S_READ;
							end
						end
						ACT_TALLY: begin
							cmd.tally_start = 1'b1;
							if (stat.empty) begin
								cmd.res_zero = 1'b1;
								start = 1'b1;
							end else begin
								state_d = S_P1;
							end
						end
						default: begin
							if (in_action == ACT_CLEAR)
								cmd.do_clear = 1'b1;
							cmd.res_zero = 1'b1;
							start = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.scan_acc = 1'b1;
				start = 1'b1;
				state_d = S_OUT;
			end
			S_P1: begin
				cmd.scan_rd = 1'b1;
				if (scan_last)
					state_d = S_P1D;
			end
			S_P1D: state_d = S_P2;
			S_P2: begin
				cmd.scan_rd = 1'b1;
				cmd.pass_two = 1'b1;
				if (scan_last)
					state_d = S_P2D;
			end
			S_P2D: begin
				cmd.pass_two = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.wb_rd = 1'b1;
				if (wb_last) begin
					cmd.wb_wr = 1'b1;
					start = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: sv/fifo_with_class_tally_promote.sv
// Bounded record FIFO with class tally and stable promotion of matching records.
// Push, clear, ignored codes and errors load the result as the input is taken; pop/peek first
// read the entry into rd_q; tally runs two scan passes and a write back, one entry per cycle.
// One transaction in flight; next input can be taken in the cycle after the result is taken.
// arst_n clears pointers, count and control; stores hold no reset value.
`default_nettype none
module fifo_with_class_tally_promote import fwct_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fwct_in_if.sink in_ch,
	fwct_out_if.source out_ch
);
	cmd_t cmd;
	stat_t stat;
	logic scan_last, wb_last;

	fwct_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat, .scan_last, .wb_last, .cmd
	);

	fwct_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .scan_last, .wb_last,
		.in_name(in_ch.name_tag), .in_prize(in_ch.prize_tag),
		.in_kind(in_ch.kind), .in_dur(in_ch.duration),
		.r_status(out_ch.status), .r_name(out_ch.out_name), .r_prize(out_ch.out_prize),
		.r_kind(out_ch.out_kind), .r_dur(out_ch.out_duration), .r_total(out_ch.total)
	);
endmodule
`default_nettype wire

// File: tb/fifo_with_class_tally_promote_tb.sv
// Testbench for the class-tally FIFO: directed and random transactions, checked
// against a behavioral queue model. Depends on fwct_pkg, fwct_if and the RTL.
`default_nettype none
module fifo_with_class_tally_promote_tb;
	import fwct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [31:0] name;
		logic [31:0] prize;
		logic [7:0] kind;
		logic [15:0] dur;
	} rec_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] name;
		logic [31:0] prize;
		logic [7:0] kind;
		logic [15:0] dur;
		logic [19:0] total;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fwct_in_if in_ch();
	fwct_out_if out_ch();

	fifo_with_class_tally_promote u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #6 clk = ~clk;

	rec_t queue_model[$];
	resp_t resp_expected[$];
	int errors = 0;
	int hold_cycles = 0;
	int out_wait = 0;
	bit rand_gaps = 1'b1;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = '0;
		in_ch.name_tag = '0;
		in_ch.prize_tag = '0;
		in_ch.kind = '0;
		in_ch.duration = '0;
		out_ch.ready = 1'b0;
	end

	function automatic resp_t predict_action(logic [2:0] act, rec_t r);
		resp_t o;
		rec_t hit[$];
		rec_t miss[$];
		logic [20:0] sum;
		o = '0;
		case (act)
			ACT_PUSH: begin
				if (queue_model.size() >= DEPTH) o.status = ST_FULL;
				else queue_model.push_back(r);
			end
			ACT_POP, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
				if (queue_model.size() == 0) o.status = ST_EMPTY;
				else begin
					if (act == ACT_PEEK_BACK) r = queue_model[$];
					else r = queue_model[0];
					if (act == ACT_POP) void'(queue_model.pop_front());
					o.name = r.name;
					o.prize = r.prize;
					o.kind = r.kind;
					o.dur = r.dur;
				end
			end
			ACT_CLEAR: queue_model.delete();
			ACT_TALLY: begin
				sum = '0;
				foreach (queue_model[i]) begin
					if (queue_model[i].kind == r.kind) begin
						hit.push_back(queue_model[i]);
						sum = sum + 21'(queue_model[i].dur);
						if (sum > {1'b0, TOTAL_MAX}) sum = {1'b0, TOTAL_MAX};
					end else miss.push_back(queue_model[i]);
				end
				queue_model = {hit, miss};
				o.total = sum[19:0];
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic send_action(logic [2:0] act, logic [31:0] nm, logic [31:0] pz,
		logic [7:0] kd, logic [15:0] du);
		int gap;
		rec_t r;
		gap = rand_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.name_tag <= nm;
		in_ch.prize_tag <= pz;
		in_ch.kind <= kd;
		in_ch.duration <= du;
		do @(posedge clk); while (!in_ch.ready);
		r = '{nm, pz, kd, du};
		resp_expected.push_back(predict_action(act, r));
	endtask

	task automatic send_random(int kind_span);
		logic [2:0] act;
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) act = ACT_PUSH;
		else if (p < 58) act = ACT_POP;
		else if (p < 68) act = ACT_PEEK_FRONT;
		else if (p < 78) act = ACT_PEEK_BACK;
		else if (p < 93) act = ACT_TALLY;
		else if (p < 96) act = ACT_CLEAR;
		else act = 3'($urandom_range(ACT_UNUSED_6, ACT_UNUSED_7));
		send_action(act, $urandom, $urandom,
			kind_span > 0 ? 8'($urandom_range(0, kind_span)) : 8'($urandom),
			16'($urandom));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (resp_expected.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				out_wait = rand_gaps ? $urandom_range(0, 16) : 0;
				if (resp_expected.size() == 0) begin
					$error("unexpected transaction status %0d", out_ch.status);
					errors++;
				end else begin
					resp_t e;
					e = resp_expected.pop_front();
					if (out_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_ch.status); errors++;
					end
					if (out_ch.out_name !== e.name) begin
						$error("out_name exp %h got %h", e.name, out_ch.out_name); errors++;
					end
					if (out_ch.out_prize !== e.prize) begin
						$error("out_prize exp %h got %h", e.prize, out_ch.out_prize); errors++;
					end
					if (out_ch.out_kind !== e.kind) begin
						$error("out_kind exp %h got %h", e.kind, out_ch.out_kind); errors++;
					end
					if (out_ch.out_duration !== e.dur) begin
						$error("out_duration exp %h got %h", e.dur, out_ch.out_duration);
						errors++;
					end
					if (out_ch.total !== e.total) begin
						$error("total exp %h got %h", e.total, out_ch.total); errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ch.ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait = out_wait - 1;
				out_ch.ready <= 1'b0;
			end else out_ch.ready <= 1'b1;
		end
	end

	task automatic test_directed();
		send_action(ACT_POP, '0, '0, '0, '0);
		send_action(ACT_PEEK_FRONT, '0, '0, '0, '0);
		send_action(ACT_PEEK_BACK, '0, '0, '0, '0);
		send_action(ACT_TALLY, '0, '0, 8'h00, '0);
		send_action(ACT_PUSH, 32'hFFFF_FFFF, 32'h0, 8'hFF, 16'hFFFF);
		send_action(ACT_PUSH, 32'h0, 32'hFFFF_FFFF, 8'h00, 16'h0000);
		send_action(ACT_PUSH, 32'h1234_5678, 32'h9ABC_DEF0, 8'hFF, 16'h8000);
		send_action(ACT_PEEK_FRONT, '0, '0, '0, '0);
		send_action(ACT_PEEK_BACK, '0, '0, '0, '0);
		send_action(ACT_TALLY, '0, '0, 8'hFF, '0);
		send_action(ACT_PEEK_BACK, '0, '0, '0, '0);
		send_action(ACT_UNUSED_6, $urandom, $urandom, 8'h55, 16'h55);
		send_action(ACT_UNUSED_7, $urandom, $urandom, 8'hAA, 16'hAA);
		send_action(ACT_POP, '0, '0, '0, '0);
		send_action(ACT_CLEAR, '0, '0, '0, '0);
		send_action(ACT_POP, '0, '0, '0, '0);
		for (int i = 0; i < DEPTH + 1; i++)
			send_action(ACT_PUSH, $urandom, $urandom, 8'hFF, 16'hFFFF);
		send_action(ACT_TALLY, '0, '0, 8'hFF, '0);
		send_action(ACT_PEEK_BACK, '0, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 10; i++) send_random(3);
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 420; i++) begin
			if (i == 200) rand_gaps = 1'b0;
			if (i == 260) rand_gaps = 1'b1;
			send_random(i < 300 ? 3 : 0);
			if (i % 97 == 0) wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
sv/fwct_pkg.sv
sv/fwct_if.sv
sv/fwct_datapath.sv
sv/fwct_ctrl.sv
sv/fifo_with_class_tally_promote.sv
tb/fifo_with_class_tally_promote_tb.sv
